FILE: sv/dsss_pkg.sv
`default_nettype none

package dsss_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned WIRING_W   = 24;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W     = 2;
    localparam int unsigned QCNT_W     = 3;

    localparam logic [COUNT_W-1:0]  DIGIT_COUNT_RESET = 4'd1;
    localparam logic [WIRING_W-1:0] WIRING_RESET      = 24'hFAC688;

    localparam logic [31:0] RECIP_TEN = 32'hCCCCCCCD;

    localparam logic [7:0] GLYPH_BLANK = 8'b00000000;

    typedef enum logic [0:0] {
        REG_DIGIT_COUNT = 1'b0,
        REG_SEGMENT_WIRING = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  digit_count;
        logic [WIRING_W-1:0] segment_wiring;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pattern;
        logic       last;
    } entry_t;

    function automatic logic [7:0] digit_glyph(input logic [3:0] digit);
        logic [7:0] g;
        begin
            case (digit)
                4'd0: g = 8'b11111100;
                4'd1: g = 8'b01100000;
                4'd2: g = 8'b11011010;
                4'd3: g = 8'b11110010;
                4'd4: g = 8'b01100110;
                4'd5: g = 8'b10110110;
                4'd6: g = 8'b10111110;
                4'd7: g = 8'b11100000;
                4'd8: g = 8'b11111110;
                4'd9: g = 8'b11110110;
                default: g = GLYPH_BLANK;
            endcase
            return g;
        end
    endfunction

    // segment n sits at glyph bit 7-n, wiring field n gives its output bit
    function automatic logic [7:0] remap_glyph(input logic [7:0] glyph,
                                               input logic [WIRING_W-1:0] wiring);
        logic [7:0] outb;
        logic [2:0] pos;
        begin
            outb = 8'h00;
            for (int seg = 0; seg < 8; seg++)
            begin
                pos = wiring[3*seg +: 3];
                if (glyph[7-seg])
                begin
                    outb[pos] = 1'b1;
                end
            end
            return outb;
        end
    endfunction

endpackage

`default_nettype wire

FILE: sv/dsss_if.sv
`default_nettype none

interface dsss_value_if;
    logic                            valid;
    logic                            ready;
    logic [dsss_pkg::VALUE_W-1:0]    value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface dsss_bit_if;
    logic valid;
    logic ready;
    logic serial_bit;
    logic latch_and_last;
    modport source (output valid, output serial_bit, output latch_and_last, input ready);
    modport sink   (input valid, input serial_bit, input latch_and_last, output ready);
endinterface

`default_nettype wire

FILE: sv/decimal_seven_segment_serializer_top.sv
// Decimal seven-segment serializer.
// value_ch takes one 32-bit unsigned number per item. bit_ch returns
// digit_count * 8 items, one serial bit each, least significant decimal digit
// first, each digit's remapped segment byte MSB first; latch_and_last marks
// the final bit of the run.
// Config: cfg_we/cfg_index/cfg_data; index 0 digit_count (low 4 bits, 0 acts
// as 1, above MAX_DIGITS acts as MAX_DIGITS), index 1 segment_wiring.
// Write config only while idle.
// Each digit byte passes from the extractor through the queue into the output shifter.
// The single-bit output shifter sets the pace; the digit extractor (one
// divide by ten per cycle while the queue is not full) runs ahead into a
// 4-entry queue, so the next number is taken while the current one is
// still shifting out.
// Reset: config returns to digit_count 1 and identity wiring; queue empties.
// A stall on bit_ch holds the current bit; the queue fills, the extractor halts,
// and value_ch ready stays low until it has pushed the number's last digit.
`default_nettype none

module decimal_seven_segment_serializer_top #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    dsss_value_if.sink                           value_ch,
    dsss_bit_if.source                           bit_ch,
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_index,
    input  wire logic [dsss_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [dsss_pkg::COUNT_W-1:0]  digit_count_reg;
    logic [dsss_pkg::WIRING_W-1:0] wiring_reg;

    dsss_pkg::cfg_t     cfg;
    dsss_pkg::entry_t   push_entry;
    dsss_pkg::entry_t   pop_entry;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= dsss_pkg::DIGIT_COUNT_RESET;
            wiring_reg      <= dsss_pkg::WIRING_RESET;
        end
        else if (cfg_we)
        begin
            case (dsss_pkg::reg_index_t'(cfg_index))
                dsss_pkg::REG_DIGIT_COUNT:
                    digit_count_reg <= cfg_data[dsss_pkg::COUNT_W-1:0];
                dsss_pkg::REG_SEGMENT_WIRING:
                    wiring_reg <= cfg_data[dsss_pkg::WIRING_W-1:0];
                default:
                    wiring_reg <= wiring_reg;
            endcase
        end
    end

    assign cfg.digit_count    = digit_count_reg;
    assign cfg.segment_wiring = wiring_reg;

    dsss_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (value_ch.valid),
        .in_ready (value_ch.ready),
        .in_value (value_ch.value),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    dsss_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (push_entry),
        .pop   (q_pop),
        .rdata (pop_entry),
        .full  (q_full),
        .empty (q_empty)
    );

    dsss_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_entry        (pop_entry),
        .q_pop          (q_pop),
        .out_valid      (bit_ch.valid),
        .out_ready      (bit_ch.ready),
        .serial_bit     (bit_ch.serial_bit),
        .latch_and_last (bit_ch.latch_and_last)
    );

endmodule

`default_nettype wire

FILE: sv/dsss_front.sv
`default_nettype none

module dsss_front #(
    parameter int unsigned MAX_DIGITS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dsss_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [dsss_pkg::VALUE_W-1:0] in_value,
    input  wire logic                         q_full,
    output logic                              q_push,
    output dsss_pkg::entry_t                  q_entry
);

    localparam logic [dsss_pkg::COUNT_W-1:0] MAX_CNT = dsss_pkg::COUNT_W'(MAX_DIGITS);

    logic [dsss_pkg::VALUE_W-1:0] n_reg, n_next;
    logic [dsss_pkg::COUNT_W-1:0] left_reg, left_next;
    logic                         busy_reg, busy_next;

    logic [63:0]                  prod;
    logic [dsss_pkg::VALUE_W-1:0] quot;
    logic [3:0]                   rem;
    logic [dsss_pkg::COUNT_W-1:0] eff_count;

    always_comb
    begin
        if (cfg.digit_count == '0)
            eff_count = dsss_pkg::COUNT_W'(1);
        else if (cfg.digit_count > MAX_CNT)
            eff_count = MAX_CNT;
        else
            eff_count = cfg.digit_count;
    end

    // n / 10 by reciprocal; remainder only needs the low nibble
    assign prod = 64'(n_reg) * 64'(dsss_pkg::RECIP_TEN);
    assign quot = dsss_pkg::VALUE_W'(prod[63:35]);
    assign rem  = 4'(n_reg[3:0] - ({quot[0], 3'b000} + {quot[2:0], 1'b0}));

    assign in_ready = !busy_reg;
    assign q_push   = busy_reg && !q_full;
    assign q_entry.pattern = dsss_pkg::remap_glyph(dsss_pkg::digit_glyph(rem),
                                                   cfg.segment_wiring);
    assign q_entry.last    = (left_reg == dsss_pkg::COUNT_W'(1));

    always_comb
    begin
        n_next    = n_reg;
        left_next = left_reg;
        busy_next = busy_reg;
        if (in_valid && in_ready)
        begin
            n_next    = in_value;
            left_next = eff_count;
            busy_next = 1'b1;
        end
        else if (q_push)
        begin
            n_next    = quot;
            left_next = left_reg - dsss_pkg::COUNT_W'(1);
            if (q_entry.last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

endmodule

`default_nettype wire

FILE: sv/dsss_queue.sv
`default_nettype none

module dsss_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire dsss_pkg::entry_t wdata,
    input  wire logic             pop,
    output dsss_pkg::entry_t      rdata,
    output logic                  full,
    output logic                  empty
);

    dsss_pkg::entry_t mem [dsss_pkg::QUEUE_DEPTH];

    logic [dsss_pkg::QPTR_W-1:0] wr_reg, wr_next;
    logic [dsss_pkg::QPTR_W-1:0] rd_reg, rd_next;
    logic [dsss_pkg::QCNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == dsss_pkg::QCNT_W'(dsss_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = wr_reg + dsss_pkg::QPTR_W'(1);
        if (pop)
            rd_next = rd_reg + dsss_pkg::QPTR_W'(1);
        if (push && !pop)
            cnt_next = cnt_reg + dsss_pkg::QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - dsss_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= wdata;
    end

endmodule

`default_nettype wire

FILE: sv/dsss_back.sv
`default_nettype none

module dsss_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_empty,
    input  wire dsss_pkg::entry_t q_entry,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  serial_bit,
    output logic                  latch_and_last
);

    logic [7:0] sh_reg, sh_next;
    logic       last_reg, last_next;
    logic [2:0] bit_reg, bit_next;
    logic       active_reg, active_next;
    logic       fire;
    logic       byte_done;

    assign out_valid      = active_reg;
    assign serial_bit     = sh_reg[7];
    assign latch_and_last = last_reg && (bit_reg == 3'd7);

    assign fire      = active_reg && out_ready;
    assign byte_done = fire && (bit_reg == 3'd7);
    assign q_pop     = (!active_reg || byte_done) && !q_empty;

    always_comb
    begin
        sh_next     = sh_reg;
        last_next   = last_reg;
        bit_next    = bit_reg;
        active_next = active_reg;
        if (q_pop)
        begin
            sh_next     = q_entry.pattern;
            last_next   = q_entry.last;
            bit_next    = 3'd0;
            active_next = 1'b1;
        end
        else if (byte_done)
        begin
            active_next = 1'b0;
        end
        else if (fire)
        begin
            sh_next  = {sh_reg[6:0], 1'b0};
            bit_next = bit_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            bit_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            bit_reg    <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg   <= sh_next;
        last_reg <= last_next;
    end

endmodule

`default_nettype wire

FILE: sim/decimal_seven_segment_serializer_top_test.sv
`timescale 1ns / 100ps

module decimal_seven_segment_serializer_top_test;

    localparam int unsigned MAX_DIGITS    = 8;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned PRESSURE_HOLD = 400;
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_ITEMS   = 55;
    localparam int unsigned PRINT_CAP     = 40;

    localparam logic [3:0]  COUNT_AT_RESET  = 4'd1;
    localparam logic [23:0] WIRING_STRAIGHT = 24'hFAC688;
    localparam logic [23:0] WIRING_REVERSED = 24'h053977;

    typedef struct {
        logic        serial_bit;
        logic        latch_and_last;
        int unsigned item_no;
        int unsigned bit_no;
    } stream_bit_t;

    class segment_scoreboard;
        logic [3:0]  digit_count;
        logic [23:0] wiring;
        stream_bit_t pending_bits[$];
        int unsigned mismatches;
        int unsigned bits_checked;
        int unsigned values_noted;

        function new();
            digit_count  = COUNT_AT_RESET;
            wiring       = WIRING_STRAIGHT;
            mismatches   = 0;
            bits_checked = 0;
            values_noted = 0;
        endfunction

        function void set_config(logic [23:0] count_data, logic [23:0] wiring_data);
            digit_count = count_data[3:0];
            wiring      = wiring_data;
        endfunction

        // abcdefg-dot, segment a in bit 7
        function logic [7:0] glyph_of(int unsigned digit);
            logic [7:0] g;
            case (digit)
                0: g = 8'b11111100;
                1: g = 8'b01100000;
                2: g = 8'b11011010;
                3: g = 8'b11110010;
                4: g = 8'b01100110;
                5: g = 8'b10110110;
                6: g = 8'b10111110;
                7: g = 8'b11100000;
                8: g = 8'b11111110;
                9: g = 8'b11110110;
                default: g = 8'b00000000;
            endcase
            return g;
        endfunction

        function logic [7:0] place_segments(logic [7:0] glyph);
            logic [7:0] placed;
            placed = 8'h00;
            for (int s = 0; s < 8; s++)
            begin
                if (glyph[7-s])
                begin
                    placed[wiring[3*s +: 3]] = 1'b1;
                end
            end
            return placed;
        endfunction

        function void note_value(logic [31:0] value);
            int unsigned rest;
            int unsigned shown;
            int unsigned k;
            logic [7:0]  pattern;
            stream_bit_t e;
            rest  = value;
            shown = (digit_count == 0) ? 1 :
                    (digit_count > MAX_DIGITS) ? MAX_DIGITS : digit_count;
            k = 0;
            for (int d = 0; d < shown; d++)
            begin
                pattern = place_segments(glyph_of(rest % 10));
                rest    = rest / 10;
                for (int b = 7; b >= 0; b--)
                begin
                    e.serial_bit     = pattern[b];
                    e.latch_and_last = (k + 1 == shown * 8);
                    e.item_no        = values_noted;
                    e.bit_no         = k;
                    pending_bits.push_back(e);
                    k++;
                end
            end
            values_noted++;
        endfunction

        task report_mismatch(string what);
            if (mismatches < PRINT_CAP)
            begin
                $display("[%0t] MISMATCH %s", $time, what);
            end
            mismatches++;
        endtask

        task check_bit(logic serial_bit, logic latch_and_last);
            stream_bit_t want;
            if (pending_bits.size() == 0)
            begin
                report_mismatch("serial bit with nothing pending");
                return;
            end
            want = pending_bits.pop_front();
            bits_checked++;
            if (serial_bit !== want.serial_bit)
            begin
                report_mismatch($sformatf("item %0d bit %0d serial_bit got %b want %b",
                    want.item_no, want.bit_no, serial_bit, want.serial_bit));
            end
            if (latch_and_last !== want.latch_and_last)
            begin
                report_mismatch($sformatf("item %0d bit %0d latch_and_last got %b want %b",
                    want.item_no, want.bit_no, latch_and_last, want.latch_and_last));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;

    dsss_value_if value_ch();
    dsss_bit_if   bit_ch();

    segment_scoreboard board;

    int unsigned gap_pct;
    int unsigned stall_pct;
    int unsigned hold_cycles;
    int unsigned quiet_cycles;
    int unsigned settings_used;

    decimal_seven_segment_serializer_top #(
        .MAX_DIGITS(MAX_DIGITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .bit_ch   (bit_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_value(input logic [31:0] value);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            value_ch.valid <= 1'b0;
            value_ch.value <= $urandom;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= value;
        @(posedge clk);
        while (!value_ch.ready)
        begin
            @(posedge clk);
        end
        board.note_value(value);
    endtask

    task automatic wait_drained();
        value_ch.valid <= 1'b0;
        while (board.pending_bits.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic reconfigure(input logic [23:0] count_data, input logic [23:0] wiring);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= dsss_pkg::REG_DIGIT_COUNT;
        cfg_data  <= count_data;
        @(posedge clk);
        cfg_index <= dsss_pkg::REG_SEGMENT_WIRING;
        cfg_data  <= wiring;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_config(count_data, wiring);
        settings_used++;
    endtask

    // receiver side: long hold on request, random stall bursts otherwise
    initial
    begin
        bit_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                bit_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                bit_ch.ready <= 1'b1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                bit_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                bit_ch.ready <= 1'b1;
            end
            else
            begin
                bit_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && bit_ch.valid === 1'b1 && bit_ch.ready === 1'b1)
        begin
            board.check_bit(bit_ch.serial_bit, bit_ch.latch_and_last);
        end
    end

    always @(posedge clk)
    begin
        if ((value_ch.valid === 1'b1 && value_ch.ready === 1'b1) ||
            (bit_ch.valid === 1'b1 && bit_ch.ready === 1'b1))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("decimal_seven_segment_serializer_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [3:0]  cnt;
        logic [19:0] junk;
        logic [23:0] wiring;
        logic [31:0] value;
        int unsigned pick;
        int unsigned p10;

        board          = new();
        gap_pct        = 20;
        stall_pct      = 5;
        hold_cycles    = 0;
        quiet_cycles   = 0;
        settings_used  = 1;
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= dsss_pkg::REG_DIGIT_COUNT;
        cfg_data       <= 24'h0;
        value_ch.valid <= 1'b0;
        value_ch.value <= 32'h0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one digit, straight wiring, every glyph
        for (int d = 0; d < 10; d++)
        begin
            send_value(d);
        end
        send_value(32'hFFFF_FFFF);

        reconfigure({20'h00000, 4'd8}, WIRING_STRAIGHT);
        send_value(32'd12345678);
        send_value(32'hFFFF_FFFF);
        send_value(32'd99999999);
        send_value(32'd100000000);
        send_value(32'd0);

        // count 0 acts as 1; every segment on bit 0
        reconfigure({20'hFFFFF, 4'd0}, 24'h000000);
        send_value(32'd8);
        send_value(32'd1);

        // count above range acts as max; every segment on bit 7
        reconfigure({20'h00000, 4'hF}, 24'hFFFFFF);
        send_value(32'h8000_0000);

        reconfigure({20'h5A5A5, 4'd3}, WIRING_REVERSED);
        send_value(32'd907);
        send_value(32'hFFFF_FFFF);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                cnt = 4'($urandom_range(1, MAX_DIGITS));
            else if (pick == 7)
                cnt = 4'd0;
            else
                cnt = 4'($urandom_range(MAX_DIGITS + 1, 15));
            junk   = 20'($urandom);
            wiring = 24'($urandom);
            if (p == 2)
                cnt = 4'd2;
            if (p == RANDOM_PHASES - 1)
                cnt = 4'(MAX_DIGITS);
            reconfigure({junk, cnt}, wiring);

            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 25;
                default: gap_pct = 60;
            endcase
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 3;
                default: stall_pct = 10;
            endcase
            if (p == 2)
            begin
                gap_pct     = 0;
                hold_cycles = PRESSURE_HOLD;
            end
            if (p == RANDOM_PHASES - 1)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(0, 3))
                    0, 1: value = $urandom;
                    2: value = $urandom_range(0, 99999);
                    default:
                    begin
                        p10 = 1;
                        repeat ($urandom_range(0, 9)) p10 = p10 * 10;
                        value = p10 + $urandom_range(0, 2) - 1;
                    end
                endcase
                send_value(value);
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (board.pending_bits.size() != 0)
        begin
            board.report_mismatch($sformatf("%0d bits never arrived",
                board.pending_bits.size()));
        end

        $display("%0d numbers shown under %0d register settings, %0d serial bits compared",
            board.values_noted, settings_used, board.bits_checked);
        $display("%0d mismatches", board.mismatches);
        if (board.mismatches == 0)
        begin
            $display("decimal_seven_segment_serializer_top verification clean");
        end
        else
        begin
            $display("decimal_seven_segment_serializer_top verification failed");
        end
        $finish;
    end

endmodule

FILE: decimal_seven_segment_serializer_top.f
sv/dsss_pkg.sv
sv/dsss_if.sv
sv/dsss_front.sv
sv/dsss_queue.sv
sv/dsss_back.sv
sv/decimal_seven_segment_serializer_top.sv
sim/decimal_seven_segment_serializer_top_test.sv
